// ----- design/source_char_tokenizer_macros.svh -----
// assertion macros shared by the tokenizer modules
`ifndef SOURCE_CHAR_TOKENIZER_MACROS_SVH
`define SOURCE_CHAR_TOKENIZER_MACROS_SVH

// clocked assertion, ignored while reset is held
`define SCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/sct_pkg.sv -----
package sct_pkg;

    // default widths of the line and column counters and of the length counter
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int DEF_LEN_WIDTH   = 8;

    // token queue between the lexer and the result port
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_WIDTH   = 3;
    localparam int LEVEL_WIDTH = 4;

    // output field widths
    localparam int OUT_LINE_WIDTH = 16;
    localparam int OUT_LEN_WIDTH  = 8;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;

    typedef enum logic [2:0] {
        ST_HOME   = 3'd0,
        ST_ERROR  = 3'd1,
        ST_NUMBER = 3'd2,
        ST_IDENT  = 3'd3,
        ST_KEY    = 3'd4,
        ST_ASSIGN = 3'd5,
        ST_STRING = 3'd6
    } lex_state_t;

    typedef enum logic [3:0] {
        CL_DIGIT  = 4'd0,
        CL_SIGN   = 4'd1,
        CL_BLANK  = 4'd2,
        CL_PREFIX = 4'd3,
        CL_ALPHA  = 4'd4,
        CL_COLON  = 4'd5,
        CL_EQ     = 4'd6,
        CL_QUOTE  = 4'd7,
        CL_OTHER  = 4'd8
    } char_class_t;

    typedef enum logic [3:0] {
        K_INTEGER  = 4'd0,
        K_DELIM    = 4'd1,
        K_ERROR    = 4'd2,
        K_VARIABLE = 4'd3,
        K_LABEL    = 4'd4,
        K_FUNCTION = 4'd5,
        K_KEYWORD  = 4'd6,
        K_ASSIGN   = 4'd7,
        K_STRING   = 4'd8
    } token_kind_t;

    typedef struct packed {
        token_kind_t                 kind;
        logic [OUT_LINE_WIDTH-1:0]   line;
        logic [OUT_LINE_WIDTH-1:0]   column;
        logic [OUT_LEN_WIDTH-1:0]    length;
        logic [7:0]                  first;
        logic                        last;
    } token_t;

    // zero, one or two tokens produced by one character
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } token_push_t;

    // character class lookup
    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cl;
        cl = CL_OTHER;
        if (c >= 8'h30 && c <= 8'h39) begin
            cl = CL_DIGIT;
        end else if (c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h5C ||
                     c == 8'h2C || c == 8'h3B || c == 8'h3C || c == 8'h3E ||
                     c == 8'h5B || c == 8'h5D || c == 8'h26 || c == 8'h7C ||
                     c == 8'h5E || c == 8'h21 || c == 8'h28 || c == 8'h29 ||
                     c == 8'h7B || c == 8'h7D) begin
            cl = CL_SIGN;
        end else if (c == CH_SPACE || c == CH_NEWLINE || c == CH_TAB) begin
            cl = CL_BLANK;
        end else if (c == CH_QMARK || c == CH_AT || c == CH_DOLLAR) begin
            cl = CL_PREFIX;
        end else if (c == CH_COLON) begin
            cl = CL_COLON;
        end else if (c == CH_EQUAL) begin
            cl = CL_EQ;
        end else if (c == CH_QUOTE) begin
            cl = CL_QUOTE;
        end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
            cl = CL_ALPHA;
        end
        return cl;
    endfunction

    // one transition of the lexer automaton
    function automatic lex_state_t next_state(input lex_state_t s, input char_class_t cl);
        logic       ends;
        lex_state_t ns;
        ends = (cl == CL_SIGN) || (cl == CL_BLANK) || (cl == CL_COLON) || (cl == CL_EQ);
        ns   = ST_ERROR;
        unique case (s)
            ST_HOME: begin
                priority if (cl == CL_SIGN || cl == CL_BLANK || cl == CL_EQ) ns = ST_HOME;
                else if (cl == CL_DIGIT)  ns = ST_NUMBER;
                else if (cl == CL_ALPHA)  ns = ST_KEY;
                else if (cl == CL_COLON)  ns = ST_ASSIGN;
                else if (cl == CL_QUOTE)  ns = ST_STRING;
                else if (cl == CL_PREFIX) ns = ST_IDENT;
                else                      ns = ST_ERROR;
            end
            ST_NUMBER: begin
                priority if (ends)           ns = ST_HOME;
                else if (cl == CL_DIGIT)     ns = ST_NUMBER;
                else                         ns = ST_ERROR;
            end
            ST_IDENT: begin
                priority if (ends)                          ns = ST_HOME;
                else if (cl == CL_DIGIT || cl == CL_ALPHA)  ns = ST_IDENT;
                else                                        ns = ST_ERROR;
            end
            ST_KEY: begin
                priority if (ends)       ns = ST_HOME;
                else if (cl == CL_ALPHA) ns = ST_KEY;
                else                     ns = ST_ERROR;
            end
            ST_ASSIGN: ns = (cl == CL_EQ) ? ST_HOME : ST_ERROR;
            ST_STRING: begin
                priority if (cl == CL_QUOTE) ns = ST_HOME;
                else if (cl == CL_OTHER)     ns = ST_ERROR;
                else                         ns = ST_STRING;
            end
            default: ns = ST_ERROR;
        endcase
        return ns;
    endfunction

    // token kind for the state being closed
    function automatic token_kind_t kind_of(input lex_state_t s, input logic [7:0] first);
        token_kind_t k;
        unique case (s)
            ST_NUMBER: k = K_INTEGER;
            ST_KEY:    k = K_KEYWORD;
            ST_ASSIGN: k = K_ASSIGN;
            ST_STRING: k = K_STRING;
            default: begin
                priority if (first == CH_AT) k = K_LABEL;
                else if (first == CH_QMARK)  k = K_FUNCTION;
                else                         k = K_VARIABLE;
            end
        endcase
        return k;
    endfunction

endpackage

// ----- design/sct_lexer.sv -----
`include "source_char_tokenizer_macros.svh"

module sct_lexer #(
    parameter int COUNT_WIDTH = sct_pkg::DEF_COUNT_WIDTH,
    parameter int LEN_WIDTH   = sct_pkg::DEF_LEN_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic [sct_pkg::LEVEL_WIDTH-1:0]   fifo_level,
    output sct_pkg::token_push_t              push
);
    import sct_pkg::*;

    localparam int SUM_WIDTH = LEVEL_WIDTH + 1;

    // input register
    logic                   in_valid_reg;
    logic [7:0]             char_reg;

    // lexer state
    lex_state_t             state_reg, state_next;
    logic                   error_seen_reg, error_seen_next;
    logic [COUNT_WIDTH-1:0] line_reg, line_next;
    logic [COUNT_WIDTH-1:0] col_reg, col_next;
    logic [COUNT_WIDTH-1:0] rep_col_reg, rep_col_next;
    logic [LEN_WIDTH-1:0]   text_len_reg, text_len_next;
    logic [7:0]             text_first_reg, text_first_next;

    char_class_t            cl;
    lex_state_t             ns_first;
    logic                   reclose;
    logic [LEN_WIDTH-1:0]   len_close;
    logic [1:0]             tok_count;
    token_t                 tok0, tok1;
    logic [SUM_WIDTH-1:0]   committed;

    // room for this request and the one already registered, two tokens each
    assign committed = SUM_WIDTH'(fifo_level) + (in_valid_reg ? SUM_WIDTH'(2) : '0);
    assign s_tready  = (committed <= SUM_WIDTH'(FIFO_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
        end
    end

    assign cl       = classify(char_reg);
    assign ns_first = next_state(state_reg, cl);
    assign reclose  = (state_reg == ST_NUMBER) || (state_reg == ST_IDENT) ||
                      (state_reg == ST_KEY);

    // line and column counters, saturating
    always_comb begin
        line_next = line_reg;
        col_next  = col_reg;
        if (in_valid_reg) begin
            if (char_reg == CH_NEWLINE) begin
                if (line_reg != {COUNT_WIDTH{1'b1}}) line_next = line_reg + 1'b1;
                col_next = '0;
            end else if (col_reg != {COUNT_WIDTH{1'b1}}) begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // next lexer state, with the closing character rerun from home
    always_comb begin
        state_next = state_reg;
        if (in_valid_reg) begin
            if (ns_first == ST_HOME && reclose) begin
                state_next = next_state(ST_HOME, cl);
            end else begin
                state_next = ns_first;
            end
        end
    end

    // token text bookkeeping and token reports
    always_comb begin
        error_seen_next = error_seen_reg;
        rep_col_next    = rep_col_reg;
        text_len_next   = text_len_reg;
        text_first_next = text_first_reg;
        tok_count       = 2'd0;
        tok0            = '0;
        tok1            = '0;
        len_close       = text_len_reg;
        if (state_reg == ST_ASSIGN && text_len_reg != {LEN_WIDTH{1'b1}}) begin
            len_close = text_len_reg + 1'b1;
        end
        if (in_valid_reg) begin
            priority if (ns_first == ST_HOME) begin
                rep_col_next = col_next;
                if (state_reg == ST_HOME) begin
                    if (cl != CL_BLANK) begin
                        tok0 = '{kind: K_DELIM, line: OUT_LINE_WIDTH'(line_next),
                                 column: OUT_LINE_WIDTH'(col_next),
                                 length: OUT_LEN_WIDTH'(1), first: char_reg, last: 1'b0};
                        tok_count = 2'd1;
                    end
                end else begin
                    tok0 = '{kind: kind_of(state_reg, text_first_reg),
                             line: OUT_LINE_WIDTH'(line_next),
                             column: OUT_LINE_WIDTH'(col_next),
                             length: OUT_LEN_WIDTH'(len_close),
                             first: text_first_reg, last: 1'b0};
                    tok_count       = 2'd1;
                    text_len_next   = '0;
                    text_first_next = '0;
                    if (reclose) begin
                        if (cl == CL_COLON) begin
                            text_len_next   = LEN_WIDTH'(1);
                            text_first_next = char_reg;
                        end else if (cl != CL_BLANK) begin
                            tok1 = '{kind: K_DELIM, line: OUT_LINE_WIDTH'(line_next),
                                     column: OUT_LINE_WIDTH'(col_next),
                                     length: OUT_LEN_WIDTH'(1), first: char_reg,
                                     last: 1'b0};
                            tok_count = 2'd2;
                        end
                    end
                end
            end else if (ns_first == ST_ERROR) begin
                if (!error_seen_reg) begin
                    error_seen_next = 1'b1;
                    tok0 = '{kind: K_ERROR, line: OUT_LINE_WIDTH'(line_next),
                             column: OUT_LINE_WIDTH'(rep_col_reg),
                             length: '0, first: '0, last: 1'b0};
                    tok_count = 2'd1;
                end
            end else begin
                // opening quote is not part of the string text
                if (!(state_reg == ST_HOME && ns_first == ST_STRING)) begin
                    if (text_len_reg == '0) text_first_next = char_reg;
                    if (text_len_reg != {LEN_WIDTH{1'b1}}) text_len_next = text_len_reg + 1'b1;
                end
            end
        end
        // mark the final token of this character
        if (tok_count == 2'd1) tok0.last = 1'b1;
        if (tok_count == 2'd2) tok1.last = 1'b1;
    end

    assign push = '{count: tok_count, tok0: tok0, tok1: tok1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_HOME;
            error_seen_reg <= 1'b0;
            line_reg       <= COUNT_WIDTH'(1);
            col_reg        <= '0;
            rep_col_reg    <= '0;
            text_len_reg   <= '0;
            text_first_reg <= '0;
        end else begin
            state_reg      <= state_next;
            error_seen_reg <= error_seen_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            rep_col_reg    <= rep_col_next;
            text_len_reg   <= text_len_next;
            text_first_reg <= text_first_next;
        end
    end

    `SCT_ASSERT(a_error_sticky, error_seen_reg |=> error_seen_reg, "error flag cleared")
    `SCT_ASSERT(a_error_state, (state_reg == ST_ERROR) == error_seen_reg, "error state mismatch")
    `SCT_ASSERT(a_home_empty, (state_reg == ST_HOME) |-> (text_len_reg == '0), "text left at home")
    `SCT_ASSERT(a_pair_last, (push.count == 2'd2) |-> (push.tok1.last && !push.tok0.last), "bad last")

endmodule

// ----- design/sct_token_fifo.sv -----
`include "source_char_tokenizer_macros.svh"

module sct_token_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sct_pkg::token_push_t              push,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output sct_pkg::token_t                   head,
    output logic [sct_pkg::LEVEL_WIDTH-1:0]   level
);
    import sct_pkg::*;

    token_t                 mem [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_WIDTH-1:0] count_reg, count_next;
    logic                   pop;

    assign m_tvalid = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];
    assign level    = count_reg;
    assign pop      = m_tvalid && m_tready;

    // token storage, up to two writes per cycle
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + 1'b1] <= push.tok1;
        end
    end

    // pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_WIDTH'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_WIDTH'(pop);
        count_next  = count_reg + LEVEL_WIDTH'(push.count) - LEVEL_WIDTH'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SCT_ASSERT(a_no_overflow, ({1'b0, count_reg} + 5'(push.count)) <= 5'(FIFO_DEPTH), "overflow")
    `SCT_ASSERT(a_ptr_level, PTR_WIDTH'(wr_ptr_reg - rd_ptr_reg) == PTR_WIDTH'(count_reg), "ptr skew")
    `SCT_ASSERT(a_level_range, count_reg <= LEVEL_WIDTH'(FIFO_DEPTH), "level out of range")

endmodule

// ----- design/source_char_tokenizer.sv -----
// Character-at-a-time lexer: each s_ request is one 8-bit source character and
// every token it finishes comes out as one m_ request, in order. A character
// gives zero, one or two tokens (a number, keyword or identifier closed by a
// delimiter gives the token and then the delimiter); m_tlast marks the final
// token of a character. One character is taken per clock: the character is
// registered, classified and run through the state machine in the next cycle,
// and its tokens go into an 8-entry queue that feeds the output. The input
// stalls only when that queue could not take two more tokens from each of the
// character in flight and a new one, so the rate drops below one per clock
// only while the output side is stalled or two-token characters pile up.
// A character's first token reaches the m_ side through the input register and
// then the queue, behind any tokens still waiting there. After the first bad
// character one error token is reported and the block stays quiet until reset,
// while still counting lines and columns.
module source_char_tokenizer #(
    parameter int COUNT_WIDTH = sct_pkg::DEF_COUNT_WIDTH,
    parameter int LEN_WIDTH   = sct_pkg::DEF_LEN_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] token_kind, [19:4] line_number, [35:20] column_number,
    // [43:36] token_length, [51:44] first_char, [55:52] zero
    output logic [55:0] m_tdata,
    output logic        m_tlast    // last_of_run
);
    import sct_pkg::*;

    token_push_t            push;
    token_t                 head;
    logic [LEVEL_WIDTH-1:0] level;

    // classification and state machine
    sct_lexer #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .LEN_WIDTH  (LEN_WIDTH)
    ) u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_level(level),
        .push      (push)
    );

    // token queue toward the result port
    sct_token_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .head    (head),
        .level   (level)
    );

    // result packing
    assign m_tdata = {4'b0000, head.first, head.length, head.column, head.line, head.kind};
    assign m_tlast = head.last;

endmodule

// ----- dv/source_char_tokenizer_tb.sv -----
module source_char_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    localparam int unsigned COUNT_TOP   = (1 << DEF_COUNT_WIDTH) - 1;
    localparam int unsigned LEN_TOP     = (1 << DEF_LEN_WIDTH) - 1;
    localparam int          STALL_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 20;

    // one character waiting to be sent
    typedef struct {
        logic [7:0] code;
        bit         drain_first;  // hold off until every token has come out
        bit         calm;         // no idling on either side
    } char_req_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    char_req_t   char_backlog[$];
    token_t      pending_tokens[$];
    int          fail_count = 0;

    // generator controls
    bit          calm_mode  = 1'b0;
    bit          hold_next  = 1'b0;
    bit          after_word = 1'b0;
    bit          stim_calm  = 1'b0;

    // lexer mirror
    lex_state_t  lx_state;
    bit          lx_failed;
    int unsigned lx_line;
    int unsigned lx_col;
    int unsigned lx_mark;
    int unsigned lx_len;
    logic [7:0]  lx_first;

    string digit_chars  = "0123456789";
    string sign_chars   = "+-*\\,;<>[]&|^!(){}";
    string blank_chars  = " \n\t";
    string prefix_chars = "?@$";
    string body_marks   = "+-*\\,;<>[]&|^!(){} \n\t?@$:=0123456789";
    string other_chars  = "#%'./_~";

    source_char_tokenizer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // token prediction
    // ------------------------------------------------------------------
    function automatic void grow_text(logic [7:0] c);
        if (lx_len == 0) lx_first = c;
        if (lx_len < LEN_TOP) lx_len++;
    endfunction

    function automatic void add_token(token_kind_t k, int unsigned len, logic [7:0] first);
        token_t t;
        t.kind   = k;
        t.line   = lx_line[15:0];
        t.column = lx_mark[15:0];
        t.length = len[7:0];
        t.first  = first;
        t.last   = 1'b0;
        pending_tokens.push_back(t);
    endfunction

    function automatic void lex_predict(logic [7:0] c);
        char_class_t cl;
        lex_state_t  prev;
        lex_state_t  nxt;
        token_kind_t k;
        token_t      t;
        bit          ends;
        bit          again;
        int          base;
        int          pass;
        base = pending_tokens.size();

        // character class
        cl = CL_OTHER;
        if (c >= "0" && c <= "9") begin
            cl = CL_DIGIT;
        end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
            cl = CL_ALPHA;
        end else begin
            case (c)
                "+", "-", "*", "\\", ",", ";", "<", ">", "[", "]",
                "&", "|", "^", "!", "(", ")", "{", "}": cl = CL_SIGN;
                " ", "\n", "\t":                      cl = CL_BLANK;
                "?", "@", "$":                        cl = CL_PREFIX;
                ":":                                  cl = CL_COLON;
                "=":                                  cl = CL_EQ;
                "\"":                                 cl = CL_QUOTE;
                default: ;
            endcase
        end
        ends = cl inside {CL_SIGN, CL_BLANK, CL_COLON, CL_EQ};

        // line and column, counted once per character
        if (c == CH_NEWLINE) begin
            if (lx_line < COUNT_TOP) lx_line++;
            lx_col = 0;
        end else if (lx_col < COUNT_TOP) begin
            lx_col++;
        end

        // a closing delimiter is run again from home
        again = 1'b1;
        for (pass = 0; pass < 2 && again; pass++) begin
            again = 1'b0;
            prev  = lx_state;
            case (prev)
                ST_HOME: begin
                    case (cl)
                        CL_SIGN, CL_BLANK, CL_EQ: nxt = ST_HOME;
                        CL_DIGIT:                 nxt = ST_NUMBER;
                        CL_ALPHA:                 nxt = ST_KEY;
                        CL_COLON:                 nxt = ST_ASSIGN;
                        CL_QUOTE:                 nxt = ST_STRING;
                        CL_PREFIX:                nxt = ST_IDENT;
                        default:                  nxt = ST_ERROR;
                    endcase
                end
                ST_NUMBER: nxt = ends ? ST_HOME : (cl == CL_DIGIT ? ST_NUMBER : ST_ERROR);
                ST_IDENT:  nxt = ends ? ST_HOME :
                                 (cl inside {CL_DIGIT, CL_ALPHA} ? ST_IDENT : ST_ERROR);
                ST_KEY:    nxt = ends ? ST_HOME : (cl == CL_ALPHA ? ST_KEY : ST_ERROR);
                ST_ASSIGN: nxt = (cl == CL_EQ) ? ST_HOME : ST_ERROR;
                ST_STRING: nxt = (cl == CL_QUOTE) ? ST_HOME :
                                 (cl == CL_OTHER ? ST_ERROR : ST_STRING);
                default:   nxt = ST_ERROR;
            endcase

            if (nxt == ST_HOME) begin
                lx_mark = lx_col;
                if (prev == ST_HOME) begin
                    if (cl != CL_BLANK) add_token(K_DELIM, 1, c);
                end else begin
                    if (prev == ST_ASSIGN) grow_text(CH_EQUAL);
                    case (prev)
                        ST_NUMBER: k = K_INTEGER;
                        ST_KEY:    k = K_KEYWORD;
                        ST_ASSIGN: k = K_ASSIGN;
                        ST_STRING: k = K_STRING;
                        default:   k = (lx_first == CH_AT)    ? K_LABEL :
                                       (lx_first == CH_QMARK) ? K_FUNCTION : K_VARIABLE;
                    endcase
                    add_token(k, lx_len, lx_first);
                    lx_len   = 0;
                    lx_first = 8'h00;
                    lx_state = ST_HOME;
                    again    = prev inside {ST_IDENT, ST_KEY, ST_NUMBER};
                end
            end else if (nxt == ST_ERROR) begin
                // only the first bad character reports
                if (!lx_failed) begin
                    lx_failed = 1'b1;
                    add_token(K_ERROR, 0, 8'h00);
                end
                lx_state = ST_ERROR;
            end else begin
                // opening quote is not part of the text
                if (!(prev == ST_HOME && nxt == ST_STRING)) grow_text(c);
                lx_state = nxt;
            end
        end

        if (pending_tokens.size() > base) begin
            t = pending_tokens.pop_back();
            t.last = 1'b1;
            pending_tokens.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------
    // character sequence building
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_from(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
    endfunction

    task automatic add_char(logic [7:0] c);
        char_req_t r;
        r.code        = c;
        r.drain_first = hold_next;
        r.calm        = calm_mode;
        hold_next     = 1'b0;
        char_backlog.push_back(r);
    endtask

    task automatic add_text(string s);
        foreach (s[i]) add_char(s[i]);
    endtask

    task automatic add_string_body(int n);
        repeat (n) add_char($urandom_range(0, 1) ? rand_letter() : pick_from(body_marks));
    endtask

    // one random well-formed lexeme; words must be followed by a closing character
    task automatic add_lexeme();
        int pick;
        pick = after_word ? $urandom_range(0, 3) : $urandom_range(0, 9);
        case (pick)
            0, 9: begin
                add_char(pick_from(sign_chars));
                after_word = 1'b0;
            end
            1: begin
                add_char(pick_from(blank_chars));
                after_word = 1'b0;
            end
            2: begin
                add_char(CH_EQUAL);
                after_word = 1'b0;
            end
            3: begin
                add_char(CH_COLON);
                add_char(CH_EQUAL);
                after_word = 1'b0;
            end
            4, 5: begin
                repeat ($urandom_range(1, 6)) add_char(pick_from(digit_chars));
                after_word = 1'b1;
            end
            6: begin
                repeat ($urandom_range(1, 8)) add_char(rand_letter());
                after_word = 1'b1;
            end
            7: begin
                add_char(pick_from(prefix_chars));
                repeat ($urandom_range(0, 6))
                    add_char($urandom_range(0, 1) ? rand_letter() : pick_from(digit_chars));
                after_word = 1'b1;
            end
            default: begin
                add_char(CH_QUOTE);
                add_string_body($urandom_range(0, 8));
                add_char(CH_QUOTE);
                after_word = 1'b0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // character driver
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge aclk) begin
        bit took;
        bit drained;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            gap_left = 0;
        end else begin
            took = s_tvalid && s_tready;
            if (took) void'(char_backlog.pop_front());
            drained = (pending_tokens.size() == 0) && !took;

            if (s_tvalid && !s_tready) begin
                // request still waiting, keep it as is
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (char_backlog.size() == 0 ||
                         (char_backlog[0].drain_first && !drained)) begin
                s_tvalid <= 1'b0;
            end else if (!char_backlog[0].calm && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid  <= 1'b1;
                s_tdata   <= char_backlog[0].code;
                stim_calm <= char_backlog[0].calm;
            end
        end
    end

    // ------------------------------------------------------------------
    // token monitor, prediction and output stalls
    // ------------------------------------------------------------------
    int stall_left   = 0;
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        token_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left   = 0;
            quiet_cycles = 0;
            lx_state     = ST_HOME;
            lx_failed    = 1'b0;
            lx_line      = 1;
            lx_col       = 0;
            lx_mark      = 0;
            lx_len       = 0;
            lx_first     = 8'h00;
        end else begin
            // compare the token against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (pending_tokens.size() == 0) begin
                    $error("unexpected token: tdata %h tlast %b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (m_tdata[3:0] !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[19:4] !== want.line) begin
                        $error("line_number: expected %0d, got %0d", want.line, m_tdata[19:4]);
                        fail_count++;
                    end
                    if (m_tdata[35:20] !== want.column) begin
                        $error("column_number: expected %0d, got %0d",
                               want.column, m_tdata[35:20]);
                        fail_count++;
                    end
                    if (m_tdata[43:36] !== want.length) begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, m_tdata[43:36]);
                        fail_count++;
                    end
                    if (m_tdata[51:44] !== want.first) begin
                        $error("first_char: expected %h, got %h", want.first, m_tdata[51:44]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready) lex_predict(s_tdata);

            // watchdog on cycles with no request moving
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end

            // output back-pressure in bursts
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!stim_calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int start;
        int next_switch;
        int trap;

        // directed: every token kind but the error token, closing by sign, colon, blank and '='
        calm_mode = 1'b0;
        add_text("7+");
        add_text("$a1:=");
        add_text("@L9 ");
        add_text("?f=");
        add_text("\"\"");
        add_text("\"a:=\"");
        add_text("zZ\t");
        add_text("=\n");

        // random well-formed lexemes, idling switched on and off in stretches
        hold_next   = 1'b1;
        after_word  = 1'b0;
        start       = char_backlog.size();
        next_switch = start;
        while (char_backlog.size() < start + 160) begin
            if (char_backlog.size() >= next_switch) begin
                calm_mode   = ($urandom_range(0, 3) == 0);
                next_switch = next_switch + 40;
            end
            if ($urandom_range(0, 49) == 0) hold_next = 1'b1;
            add_lexeme();
        end
        if (after_word) add_char(CH_SPACE);

        // long tokens, no idling from here on
        calm_mode = 1'b1;
        hold_next = 1'b1;
        repeat (258) add_char(rand_letter());
        add_char(";");
        add_char(CH_QUOTE);
        add_string_body(20);
        add_char(CH_QUOTE);
        add_text("ab+9;");

        // the single bad character, then silence while counting goes on
        hold_next = 1'b1;
        trap = $urandom_range(0, 5);
        case (trap)
            0: add_char($urandom_range(0, 1) ? 8'h80 + 8'($urandom_range(0, 127))
                                             : pick_from(other_chars));
            1: add_text("12a");
            2: add_text("ab3");
            3: add_text(":+");
            4: begin
                add_text("\"a");
                add_char(8'hFF);
            end
            default: add_text("$x.");
        endcase
        add_char(8'h00);
        add_char(8'hFF);
        repeat (40) add_char($urandom_range(0, 255));

        // reset
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_backlog.size() != 0 || pending_tokens.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_tokens.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/sct_pkg.sv
design/sct_lexer.sv
design/sct_token_fifo.sv
design/source_char_tokenizer.sv
dv/source_char_tokenizer_tb.sv
